### rtl/mam3_pkg.sv
package mam3_pkg;

    // default matrix dimension
    localparam int SIZE_DEF = 3;

    // field widths
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 32;

    // stream word widths, packed fields padded to whole bytes
    localparam int IN_FIELDS_W  = 2 * IDX_W + DATA_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * IDX_W + DATA_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_A = 2'd0,
        KIND_LOAD_B = 2'd1,
        KIND_SUM    = 2'd2,
        KIND_PROD   = 2'd3
    } kind_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HOLD,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

endpackage

### rtl/matrix_add_multiply_3x3_core.sv
// load word: written straight into the A or B memory in its accept cycle
// sum: each element waits for the output slot, then is read, added and emitted
// product: each element makes one read of A and B per
// multiply-accumulate step through the shared multiplier
// input is held off (tready low) from a compute word until its last element is made
// reset (rst_n, async, active low) clears control; matrix memories stay undefined
module matrix_add_multiply_3x3_core #(
    parameter int SIZE = mam3_pkg::SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // row [1:0], col [3:2], value [35:4], zero pad
    input  logic [mam3_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // kind [1:0]
    input  logic [mam3_pkg::KIND_W-1:0]     s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_row [1:0], out_col [3:2], result_value [35:4], zero pad
    output logic [mam3_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    import mam3_pkg::*;

    localparam int CELLS   = SIZE * SIZE;
    localparam int AW      = $clog2(CELLS);
    localparam int IW      = $clog2(SIZE);
    localparam int OUT_PAD = OUT_TDATA_W - OUT_FIELDS_W;

    // input word fields
    logic [IDX_W-1:0]  in_row;
    logic [IDX_W-1:0]  in_col;
    logic [DATA_W-1:0] in_value;
    kind_t             in_kind;
    logic              in_acc;
    logic              in_range;
    logic              is_compute;

    state_t state_reg, state_next;

    // walk counters
    logic [IW-1:0] r_reg, r_next;
    logic [IW-1:0] c_reg, c_next;
    logic [IW-1:0] k_reg, k_next;
    logic          op_sum_reg, op_sum_next;

    // pipeline
    logic              rd_v_reg, rd_first_reg, rd_last_reg;
    logic              prod_v_reg, prod_first_reg, prod_last_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_sum;

    // output register
    logic              m_valid_reg;
    logic [IDX_W-1:0]  m_row_reg;
    logic [IDX_W-1:0]  m_col_reg;
    logic [DATA_W-1:0] m_value_reg;
    logic              m_last_reg;

    // memory ports
    logic              we_a, we_b;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     a_raddr, b_raddr;
    logic [DATA_W-1:0] a_rdata, b_rdata;

    logic issue;
    logic k_last;
    logic cell_done;
    logic cell_last;
    logic out_free;
    logic out_take;

    // unpack input word
    assign in_row   = s_axis_tdata[IDX_W-1:0];
    assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_value = s_axis_tdata[IN_FIELDS_W-1:2*IDX_W];
    assign in_kind  = kind_t'(s_axis_tuser);

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign in_range   = (int'(in_row) < SIZE) && (int'(in_col) < SIZE);
    assign is_compute = (in_kind == KIND_SUM) || (in_kind == KIND_PROD);

    // load path writes in the accept cycle; reads only run outside idle
    assign waddr = AW'(int'(in_row) * SIZE + int'(in_col));
    assign we_a  = in_acc && in_range && (in_kind == KIND_LOAD_A);
    assign we_b  = in_acc && in_range && (in_kind == KIND_LOAD_B);

    // sum reads A[r][c] and B[r][c]; product reads A[r][k] and B[k][c]
    assign a_raddr = AW'(int'(r_reg) * SIZE + int'(op_sum_reg ? c_reg : k_reg));
    assign b_raddr = AW'(int'(op_sum_reg ? r_reg : k_reg) * SIZE + int'(c_reg));

    mam3_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (in_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mam3_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (in_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // status
    assign k_last    = op_sum_reg || (k_reg == IW'(SIZE - 1));
    assign cell_done = prod_v_reg && prod_last_reg;
    assign cell_last = (r_reg == IW'(SIZE - 1)) && (c_reg == IW'(SIZE - 1));
    assign out_take  = m_valid_reg && m_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign acc_sum   = prod_first_reg ? prod_reg : acc_reg + prod_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && is_compute)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (cell_done)
                begin
                    state_next = cell_last ? ST_IDLE : ST_HOLD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_HOLD:  issue         = 1'b0;
            ST_ISSUE: issue         = 1'b1;
            ST_DRAIN: issue         = 1'b0;
            default:  issue         = 1'b0;
        endcase
    end

    // counter updates
    always_comb
    begin
        r_next      = r_reg;
        c_next      = c_reg;
        k_next      = k_reg;
        op_sum_next = op_sum_reg;
        if (in_acc && is_compute)
        begin
            r_next      = '0;
            c_next      = '0;
            k_next      = '0;
            op_sum_next = (in_kind == KIND_SUM);
        end
        if (issue)
        begin
            k_next = k_last ? '0 : k_reg + 1'b1;
        end
        if (cell_done)
        begin
            if (c_reg == IW'(SIZE - 1))
            begin
                c_next = '0;
                r_next = (r_reg == IW'(SIZE - 1)) ? '0 : r_reg + 1'b1;
            end
            else
            begin
                c_next = c_reg + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            op_sum_reg    <= 1'b0;
            rd_v_reg      <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_v_reg    <= 1'b0;
            prod_first_reg <= 1'b0;
            prod_last_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            r_reg          <= r_next;
            c_reg          <= c_next;
            k_reg          <= k_next;
            op_sum_reg     <= op_sum_next;
            rd_v_reg       <= issue;
            rd_first_reg   <= (k_reg == '0);
            rd_last_reg    <= k_last;
            prod_v_reg     <= rd_v_reg;
            prod_first_reg <= rd_first_reg;
            prod_last_reg  <= rd_last_reg;
            if (cell_done)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath: add or multiply, then accumulate
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            prod_reg <= op_sum_reg ? a_rdata + b_rdata : a_rdata * b_rdata;
        end
        if (prod_v_reg)
        begin
            acc_reg <= acc_sum;
        end
        if (cell_done)
        begin
            m_row_reg   <= IDX_W'(r_reg);
            m_col_reg   <= IDX_W'(c_reg);
            m_value_reg <= acc_sum;
            m_last_reg  <= cell_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, m_value_reg, m_col_reg, m_row_reg};

    // pipeline is empty whenever the sequencer is idle
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_v_reg && !prod_v_reg))
        else $error("pipeline busy while idle");

    // a finished element never lands on an occupied output register
    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cell_done |-> (!m_valid_reg || m_axis_tready))
        else $error("output overrun");

    // the last element leaves the walk counters wrapped to zero
    a_last_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_last_reg) |-> (r_reg == '0 && c_reg == '0))
        else $error("walk counters not wrapped after last element");

    // reads are only issued while input is held off
    a_no_load_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (issue || rd_v_reg || prod_v_reg) |-> !s_axis_tready)
        else $error("input open during a compute walk");

endmodule

### rtl/mam3_ram.sv
module mam3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
